// ===== src/itaf_pkg.sv =====
`default_nettype none

package itaf_pkg;

    // Bus widths: fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;
    localparam int VALUE_W   = 64;
    localparam int CHAR_W    = 7;

    // Format selector codes
    localparam logic [1:0] FUNC_DEC  = 2'd0;
    localparam logic [1:0] FUNC_BIN  = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CH_HEX_OFS = 7'd55;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'd45;
    localparam logic [CHAR_W-1:0] CH_X       = 7'd120;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic conv;
        logic pfx;
        logic dig;
    } itaf_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic conv_last;
        logic pfx_none;
        logic dig_skip;
        logic dig_last;
        logic out_free;
    } itaf_stat_t;

    // One digit (0..15) to its uppercase ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {3'b000, d};
        return (d < 4'd10) ? (CH_ZERO + dx) : (CH_HEX_OFS + dx);
    endfunction

endpackage

`default_nettype wire

// ===== src/itaf_ctrl.sv =====
`default_nettype none

module itaf_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire  [1:0]            s_func,
    output logic                  s_tready,
    input  itaf_pkg::itaf_stat_t  stat,
    output itaf_pkg::itaf_cmd_t   cmd
);
    import itaf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PFX  = 4'b0100,
        S_DIG  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_func) inside
                        FUNC_DEC: begin
                            cmd.load   = 1'b1;
                            state_next = S_CONV;
                        end
                        FUNC_BIN, FUNC_HEX: begin
                            cmd.load   = 1'b1;
                            state_next = S_PFX;
                        end
                        default: ; // unused selector: transaction dropped
                    endcase
                end
            end
            S_CONV: begin
                cmd.conv = 1'b1;
                if (stat.conv_last) state_next = S_PFX;
            end
            S_PFX: begin
                if (stat.pfx_none) begin
                    state_next = S_DIG;
                end else if (stat.out_free) begin
                    cmd.pfx = 1'b1;
                end
            end
            S_DIG: begin
                if (stat.dig_skip || stat.out_free) begin
                    cmd.dig = 1'b1;
                    if (stat.dig_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Final character returns the controller to idle
    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIG && cmd.dig && stat.dig_last) |=> state_reg == S_IDLE)
        else $error("itaf_ctrl: not idle after final character");

    // Unused selector produces no work
    a_drop_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_func == FUNC_NONE) |=> state_reg == S_IDLE)
        else $error("itaf_ctrl: unused selector started a conversion");

endmodule

`default_nettype wire

// ===== src/itaf_dpath.sv =====
`default_nettype none

module itaf_dpath #(
    parameter int VALUE_BITS = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [1:0]                       s_func,
    input  wire  [itaf_pkg::VALUE_W-1:0]     s_value,
    input  itaf_pkg::itaf_cmd_t              cmd,
    output itaf_pkg::itaf_stat_t             stat,
    input  wire                              m_tready,
    output logic                             m_tvalid,
    output logic [itaf_pkg::CHAR_W-1:0]      m_char,
    output logic                             m_last
);
    import itaf_pkg::*;

    localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;  // decimal digit slots
    localparam int NHEX = (VALUE_BITS + 3) / 4;       // hex digit slots
    localparam int SRW  = 4 * NDIG;                   // BCD / digit shifter width
    localparam int HXW  = 4 * NHEX;
    localparam int CW   = $clog2(HXW + 1);

    logic [1:0]            func_reg, func_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [SRW-1:0]        sr_reg, sr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [1:0]            pfx_reg, pfx_next;
    logic                  nz_reg, nz_next;
    logic                  valid_reg, valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    logic [VALUE_BITS-1:0] word;
    logic                  neg;
    logic [SRW-1:0]        sr_adj;
    logic [3:0]            top;
    logic                  out_free;
    logic                  skip;
    logic                  cnt_one;
    logic [CHAR_W-1:0]     pfx_char;

    assign word     = s_value[VALUE_BITS-1:0];
    assign neg      = (s_func == FUNC_DEC) && word[VALUE_BITS-1];
    assign out_free = !valid_reg || m_tready;
    assign cnt_one  = (cnt_reg == CW'(1));
    assign top      = (func_reg == FUNC_BIN) ? {3'b000, sr_reg[SRW-1]} : sr_reg[SRW-1 -: 4];
    assign skip     = (top == 4'd0) && !nz_reg && !cnt_one;
    assign pfx_char = (func_reg == FUNC_DEC) ? CH_MINUS :
                      ((pfx_reg == 2'd2) ? CH_ZERO : CH_X);

    // Double-dabble add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            sr_adj[4*i +: 4] = (sr_reg[4*i +: 4] >= 4'd5) ? (sr_reg[4*i +: 4] + 4'd3)
                                                          : sr_reg[4*i +: 4];
        end
    end

    assign stat.conv_last = cnt_one;
    assign stat.pfx_none  = (pfx_reg == 2'd0);
    assign stat.dig_skip  = skip;
    assign stat.dig_last  = cnt_one;
    assign stat.out_free  = out_free;

    // Work registers
    always_comb begin
        func_next = func_reg;
        mag_next  = mag_reg;
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        pfx_next  = pfx_reg;
        nz_next   = nz_reg;
        if (cmd.load) begin
            func_next = s_func;
            nz_next   = 1'b0;
            mag_next  = neg ? (~word + 1'b1) : word;
            if (s_func == FUNC_DEC) begin
                sr_next  = '0;
                cnt_next = CW'(VALUE_BITS);
                pfx_next = neg ? 2'd1 : 2'd0;
            end else begin
                // left-align the word on a nibble boundary
                sr_next  = {{(SRW-VALUE_BITS){1'b0}}, word} << (SRW - HXW);
                cnt_next = (s_func == FUNC_BIN) ? CW'(HXW) : CW'(NHEX);
                pfx_next = (s_func == FUNC_HEX) ? 2'd2 : 2'd0;
            end
        end else if (cmd.conv) begin
            sr_next  = {sr_adj[SRW-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_one ? CW'(NDIG) : (cnt_reg - 1'b1);
        end else if (cmd.pfx) begin
            pfx_next = pfx_reg - 2'd1;
        end else if (cmd.dig) begin
            sr_next  = (func_reg == FUNC_BIN) ? {sr_reg[SRW-2:0], 1'b0}
                                              : {sr_reg[SRW-5:0], 4'b0000};
            cnt_next = cnt_reg - 1'b1;
            nz_next  = nz_reg || (top != 4'd0);
        end
    end

    // Output register
    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.pfx) begin
            valid_next = 1'b1;
            char_next  = pfx_char;
            last_next  = 1'b0;
        end else if (cmd.dig && !skip) begin
            valid_next = 1'b1;
            char_next  = digit_char(top);
            last_next  = cnt_one;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        mag_reg  <= mag_next;
        sr_reg   <= sr_next;
        cnt_reg  <= cnt_next;
        pfx_reg  <= pfx_next;
        nz_reg   <= nz_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_char   = char_reg;
    assign m_last   = last_reg;

    // A character is only written into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pfx || (cmd.dig && !skip)) |-> out_free)
        else $error("itaf_dpath: output register overwritten");

    // Position counter never underflows while stepping
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.dig || cmd.conv) |-> cnt_reg != '0)
        else $error("itaf_dpath: step with empty position counter");

endmodule

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter.
// Slave stream takes one word per transaction: s_tdata[1:0] selects the format
// (0 signed decimal, 1 binary, 2 hex with "0x"), s_tdata[65:2] holds the word,
// of which the low VALUE_BITS bits are used. Selector 3 is swallowed silently.
// Master stream returns the text one ASCII character per transaction, most
// significant first, with m_tlast on the final character.
// Decimal text comes from the shift-and-add-3 BCD loop, one input bit per cycle,
// with a minus sign in front of a negative word; output is one character per
// cycle from a digit shifter while the output register is free (m_tready
// allowing), leading zeros skipped at one position per cycle.
// A new word is taken only when the previous one has been fully handed to
// the output register; the registered output decouples a stalled receiver
// for one character, after which the converter waits on m_tready.
// Reset (aresetn low, synchronous) returns to idle and empties the output.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [itaf_pkg::S_TDATA_W-1:0]   s_tdata,  // [1:0] func, [65:2] value
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [itaf_pkg::M_TDATA_W-1:0]   m_tdata,  // [6:0] text_char
    output logic                             m_tlast
);
    import itaf_pkg::*;

    itaf_cmd_t         cmd;
    itaf_stat_t        stat;
    logic [1:0]        s_func;
    logic [VALUE_W-1:0] s_value;
    logic [CHAR_W-1:0] m_char;

    assign s_func  = s_tdata[1:0];
    assign s_value = s_tdata[VALUE_W+1:2];
    assign m_tdata = {{(M_TDATA_W-CHAR_W){1'b0}}, m_char};

    itaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_func),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    itaf_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_func   (s_func),
        .s_value  (s_value),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_char   (m_char),
        .m_last   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sim/itaf_text_checker.sv =====
`default_nettype none

module itaf_text_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [itaf_pkg::S_TDATA_W-1:0]   s_tdata,  // [1:0] func, [65:2] value
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [itaf_pkg::M_TDATA_W-1:0]   m_tdata,  // [6:0] text_char
    input  wire                             m_tlast,
    output int                              fail_count,
    output int                              chars_left,
    output int                              chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import itaf_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t pending_chars[$];
    text_char_t want;

    // One line per mismatch, capped so a broken block cannot flood the log
    task automatic report_error(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Queue the characters a word should produce, most significant first
    function automatic void queue_text(input logic [1:0] fmt, input logic [VALUE_W-1:0] word);
        logic [CHAR_W-1:0] rev[64];
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit;
        logic               neg;
        text_char_t         item;
        int                 n;
        n   = 0;
        mag = word;
        case (fmt)
            FUNC_DEC: begin
                // magnitude taken unsigned so the most negative word is exact
                neg = word[VALUE_W-1];
                if (neg)
                    mag = ~word + 1'b1;
                do begin
                    digit  = 4'(mag % 64'd10);
                    rev[n] = CH_ZERO + {3'b000, digit};
                    n++;
                    mag    = mag / 64'd10;
                end while (mag != 0);
                if (neg) begin
                    rev[n] = CH_MINUS;
                    n++;
                end
            end
            FUNC_BIN: begin
                do begin
                    rev[n] = CH_ZERO + {6'd0, mag[0]};
                    n++;
                    mag    = mag >> 1;
                end while (mag != 0);
            end
            FUNC_HEX: begin
                do begin
                    digit  = mag[3:0];
                    rev[n] = (digit < 4'd10) ? CH_ZERO + {3'b000, digit}
                                             : CH_HEX_OFS + {3'b000, digit};
                    n++;
                    mag    = mag >> 4;
                end while (mag != 0);
                rev[n] = CH_X;
                rev[n+1] = CH_ZERO;
                n += 2;
            end
            default: ;  // unused selector: swallowed, no text
        endcase
        for (int k = n - 1; k >= 0; k--) begin
            item.code = rev[k];
            item.last = (k == 0);
            pending_chars.insert(pending_chars.size(), item);
        end
    endfunction

    // Watch both channels at each edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_chars.delete();
            fail_count = 0;
            chars_seen = 0;
        end else begin
            if (s_tvalid && s_tready)
                queue_text(s_tdata[1:0], s_tdata[VALUE_W+1:2]);
            if (m_tvalid && m_tready) begin
                chars_seen++;
                if (pending_chars.size() == 0) begin
                    report_error($sformatf("character 0x%02h with no text pending",
                                           m_tdata[CHAR_W-1:0]));
                end else begin
                    want = pending_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.code)
                        report_error($sformatf("char #%0d: got 0x%02h, want 0x%02h ('%c')",
                                               chars_seen, m_tdata[CHAR_W-1:0],
                                               want.code, want.code));
                    if (m_tlast !== want.last)
                        report_error($sformatf("char #%0d: tlast %b, want %b",
                                               chars_seen, m_tlast, want.last));
                end
            end
        end
        chars_left <= pending_chars.size();
    end

endmodule

`default_nettype wire

// ===== sim/integer_to_ascii_formatter_tb.sv =====
`default_nettype none

module integer_to_ascii_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itaf_pkg::*;

    localparam int RANDOM_WORDS = 185;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 120;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [1:0] func, [65:2] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [6:0] text_char
    logic                 m_tlast;

    int  fail_count;
    int  chars_left;
    int  chars_seen;
    int  idle_cycles = 0;
    int  fmt_count[4];
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    integer_to_ascii_formatter #(
        .VALUE_BITS (VALUE_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itaf_text_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .chars_left (chars_left),
        .chars_seen (chars_seen)
    );

    // Receiver backpressure: ~6% stall cycles, none during the steady stretch
    always @(posedge aclk) begin
        m_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d chars outstanding",
                         STALL_LIMIT, chars_left);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one word and hold it until accepted
    task automatic send_word(input logic [1:0] fmt, input logic [VALUE_W-1:0] word);
        while (!tx_steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-2){1'b0}}, word, fmt};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        fmt_count[fmt]++;
    endtask

    // Stop sending and let every queued character drain
    task automatic drain_text;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_left != 0)
            @(posedge aclk);
    endtask

    // Value mix: full range, short words, small and negative numbers, near powers of ten
    function automatic logic [VALUE_W-1:0] pick_word();
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] p;
        w = {$urandom, $urandom};
        case ($urandom_range(5))
            0: ;
            1: w = w >> $urandom_range(VALUE_W - 1);
            2: w = 64'($urandom_range(1000));
            3: w = -64'($urandom_range(1000));
            4: w = ~(w >> $urandom_range(VALUE_W - 1));
            default: begin
                p = 64'd1;
                repeat ($urandom_range(19)) p = p * 64'd10;
                w = p - 64'd1 + 64'($urandom_range(2));
                if ($urandom_range(1))
                    w = -w;
            end
        endcase
        return w;
    endfunction

    initial begin
        logic [1:0] fmt;
        int         n_random;
        bit         paused;
        n_random = 0;
        paused   = 1'b0;
        foreach (fmt_count[i])
            fmt_count[i] = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of each format and the ignored selector
        send_word(FUNC_DEC, 64'd0);
        send_word(FUNC_DEC, 64'd1);
        send_word(FUNC_DEC, 64'd9);
        send_word(FUNC_DEC, 64'd10);
        send_word(FUNC_DEC, '1);
        send_word(FUNC_DEC, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(FUNC_DEC, 64'h8000_0000_0000_0000);
        send_word(FUNC_DEC, 64'd10_000_000_000_000_000_000);
        send_word(FUNC_BIN, 64'd0);
        send_word(FUNC_BIN, 64'd1);
        send_word(FUNC_BIN, '1);
        send_word(FUNC_BIN, 64'h8000_0000_0000_0000);
        send_word(FUNC_NONE, 64'd0);
        send_word(FUNC_HEX, 64'd0);
        send_word(FUNC_HEX, 64'd10);
        send_word(FUNC_HEX, '1);
        send_word(FUNC_HEX, 64'h0123_4567_89AB_CDEF);
        send_word(FUNC_HEX, 64'hFEDC_BA98_7654_3210);
        send_word(FUNC_NONE, '1);
        send_word(FUNC_DEC, 64'd42);

        // Random words; selector 3 now and then, not counted
        while (n_random < RANDOM_WORDS) begin
            tx_steady = (n_random >= 120 && n_random < 170);
            rx_steady = tx_steady;
            if (n_random == 90 && !paused) begin
                drain_text();
                paused = 1'b1;
            end
            fmt = ($urandom_range(99) < 5) ? FUNC_NONE : 2'($urandom_range(2));
            send_word(fmt, pick_word());
            if (fmt != FUNC_NONE)
                n_random++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        drain_text();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run: %0d decimal, %0d binary, %0d hex words, %0d ignored selectors",
                 fmt_count[FUNC_DEC], fmt_count[FUNC_BIN], fmt_count[FUNC_HEX],
                 fmt_count[FUNC_NONE]);
        $display("     %0d characters checked under random stalls on both sides, %0d errors",
                 chars_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
